FILE: design/mte_pkg.sv
`timescale 1ns / 1ps
package mte_pkg;

	// field widths of the stream payload
	localparam int DELTA_IN_W   = 28;
	localparam int BYTE_W       = 8;
	localparam int BPM_W        = 16;
	localparam int OPCODE_W     = 3;
	localparam int S_TDATA_W    = 88;
	localparam int M_TDATA_W    = 8;
	localparam int DELTA_BITS_DEF = 28;

	// bit positions in the slave tdata
	localparam int POS_DELTA  = 0;
	localparam int POS_STATUS = 28;
	localparam int POS_A      = 36;
	localparam int POS_B      = 44;
	localparam int POS_C      = 52;
	localparam int POS_D      = 60;
	localparam int POS_BPM    = 68;

	// variable-length quantity: up to four 7-bit groups
	localparam int VLQ_BITS  = 28;
	localparam int VLQ_IDX_W = 2;

	// tempo divider: 60000000 / bpm, one quotient bit per cycle
	localparam int DIVIDEND_W = 26;
	localparam logic [DIVIDEND_W-1:0] TEMPO_DIVIDEND = 26'd60000000;
	localparam int DIV_CNT_W  = 5;
	localparam int TEMPO_Q_W  = 24;

	// meta event bytes
	localparam logic [7:0] META_PREFIX     = 8'hFF;
	localparam logic [7:0] META_TEMPO      = 8'h51;
	localparam logic [7:0] META_TEMPO_LEN  = 8'h03;
	localparam logic [7:0] META_TSIG       = 8'h58;
	localparam logic [7:0] META_TSIG_LEN   = 8'h04;
	localparam logic [7:0] META_END        = 8'h2F;
	localparam logic [7:0] META_END_LEN    = 8'h00;
	localparam logic [7:0] STATUS_RESET    = 8'hFF;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD_DELTA = 3'd0,
		OP_NOTE      = 3'd1,
		OP_TEMPO     = 3'd2,
		OP_TIME_SIG  = 3'd3,
		OP_TRACK_END = 3'd4
	} opcode_t;

	// microprogram
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_VLQ   = 5'd0;
	localparam logic [PC_W-1:0] PC_NOTE  = 5'd1;
	localparam logic [PC_W-1:0] PC_TEMPO = 5'd4;
	localparam logic [PC_W-1:0] PC_TSIG  = 5'd11;
	localparam logic [PC_W-1:0] PC_END   = 5'd18;

	typedef enum logic [3:0] {
		SRC_NONE,
		SRC_CONST,
		SRC_VLQ,
		SRC_STATUS,
		SRC_A,
		SRC_B,
		SRC_C,
		SRC_D,
		SRC_Q_HI,
		SRC_Q_MID,
		SRC_Q_LO
	} byte_src_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_VLQ,
		SEQ_DIV_WAIT,
		SEQ_END
	} seq_t;

	typedef struct packed {
		byte_src_t   src;
		logic [7:0]  const_byte;
		logic        last;
		seq_t        seq;
	} ucode_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

FILE: design/mte_ucode.sv
`timescale 1ns / 1ps
module mte_ucode
	import mte_pkg::*;
(
	input  logic [PC_W-1:0] pc,
	output ucode_t          word
);

	// control store, one word per step
	always_comb begin
		case (pc)
			PC_VLQ:            word = '{SRC_VLQ, 8'h00, 1'b0, SEQ_VLQ};
			// note event
			PC_NOTE:           word = '{SRC_STATUS, 8'h00, 1'b0, SEQ_NEXT};
			PC_NOTE + 5'd1:    word = '{SRC_A, 8'h00, 1'b0, SEQ_NEXT};
			PC_NOTE + 5'd2:    word = '{SRC_B, 8'h00, 1'b1, SEQ_END};
			// tempo
			PC_TEMPO:          word = '{SRC_CONST, META_PREFIX, 1'b0, SEQ_NEXT};
			PC_TEMPO + 5'd1:   word = '{SRC_CONST, META_TEMPO, 1'b0, SEQ_NEXT};
			PC_TEMPO + 5'd2:   word = '{SRC_CONST, META_TEMPO_LEN, 1'b0, SEQ_NEXT};
			PC_TEMPO + 5'd3:   word = '{SRC_NONE, 8'h00, 1'b0, SEQ_DIV_WAIT};
			PC_TEMPO + 5'd4:   word = '{SRC_Q_HI, 8'h00, 1'b0, SEQ_NEXT};
			PC_TEMPO + 5'd5:   word = '{SRC_Q_MID, 8'h00, 1'b0, SEQ_NEXT};
			PC_TEMPO + 5'd6:   word = '{SRC_Q_LO, 8'h00, 1'b1, SEQ_END};
			// time signature
			PC_TSIG:           word = '{SRC_CONST, META_PREFIX, 1'b0, SEQ_NEXT};
			PC_TSIG + 5'd1:    word = '{SRC_CONST, META_TSIG, 1'b0, SEQ_NEXT};
			PC_TSIG + 5'd2:    word = '{SRC_CONST, META_TSIG_LEN, 1'b0, SEQ_NEXT};
			PC_TSIG + 5'd3:    word = '{SRC_A, 8'h00, 1'b0, SEQ_NEXT};
			PC_TSIG + 5'd4:    word = '{SRC_B, 8'h00, 1'b0, SEQ_NEXT};
			PC_TSIG + 5'd5:    word = '{SRC_C, 8'h00, 1'b0, SEQ_NEXT};
			PC_TSIG + 5'd6:    word = '{SRC_D, 8'h00, 1'b1, SEQ_END};
			// track end
			PC_END:            word = '{SRC_CONST, META_PREFIX, 1'b0, SEQ_NEXT};
			PC_END + 5'd1:     word = '{SRC_CONST, META_END, 1'b0, SEQ_NEXT};
			PC_END + 5'd2:     word = '{SRC_CONST, META_END_LEN, 1'b1, SEQ_END};
			default:           word = '{SRC_NONE, 8'h00, 1'b0, SEQ_END};
		endcase
	end

endmodule

FILE: design/mte_div.sv
`timescale 1ns / 1ps
module mte_div
	import mte_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [BPM_W-1:0]     divisor,
	output logic                 busy,
	output logic [TEMPO_Q_W-1:0] quotient
);

	logic [BPM_W-1:0]      rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [BPM_W-1:0]      div_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic [BPM_W:0]        rem_sh;
	logic                  ge;
	logic [BPM_W:0]        rem_n;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
		ge     = rem_sh >= {1'b0, div_q};
		rem_n  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath, zero tempo counts as one
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= TEMPO_DIVIDEND;
			div_q <= (divisor == '0) ? BPM_W'(1) : divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the divisor width
			rem_q <= rem_n[BPM_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q[TEMPO_Q_W-1:0];

endmodule

FILE: design/midi_track_event_encoder.sv
`timescale 1ns / 1ps
// MIDI track event encoder
// slave stream: one item per operation, tuser carries the opcode (add delta,
// note event, tempo, time signature, track end); tdata carries the operands.
// master stream: one byte per item, tlast marks the final byte of an operation.
// add delta and unused opcodes produce no bytes and s_axis_tready stays high.
// every other operation is run by a microcoded sequencer at one step per cycle
// unless stalled: the pending delta as 1 to 4 bytes, then the event bytes.
// a note event with running status still runs its status step, with no byte.
// tempo is set by the bit-serial divider for 60000000 / bpm, started at
// acceptance; the sequencer waits for the quotient before its three bytes.
// the first byte is produced in the run state and leaves through the output register.
// when the receiver stalls the sequencer holds on the next byte-producing step;
// the output register keeps its byte until taken.
// reset clears the pending delta to 0, running status to 0xFF and empties
// the output register; the block is ready straight out of reset.
module midi_track_event_encoder
	import mte_pkg::*;
#(
	parameter int DELTA_BITS = DELTA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// delta_ticks, status_byte, data_a, data_b, data_c, data_d, beats_per_minute, pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// opcode
	input  logic [OPCODE_W-1:0]  s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_byte
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast
);

	localparam logic [VLQ_BITS:0] DELTA_MAX = (VLQ_BITS+1)'((64'd1 << DELTA_BITS) - 64'd1);

	state_t                state_q, state_d;
	logic [PC_W-1:0]       pc_q, pc_d;
	logic [VLQ_IDX_W-1:0]  vlq_idx_q;
	logic [VLQ_BITS-1:0]   vlq_q;
	logic [DELTA_BITS-1:0] pending_q;
	logic [7:0]            last_status_q;
	opcode_t               op_q;
	logic [7:0]            status_q, a_q, b_q, c_q, d_q;
	logic                  m_valid_q, m_last_q;
	logic [7:0]            m_data_q;

	ucode_t                uword;
	logic                  accept_in, start_run, accum, emit, vlq_dec, status_emit;
	logic                  out_free, want_emit, div_start, div_busy;
	logic [7:0]            out_byte;
	logic [TEMPO_Q_W-1:0]  tempo_q;
	logic [VLQ_BITS:0]     sum;
	logic [VLQ_BITS-1:0]   pend_ext;
	logic [VLQ_IDX_W-1:0]  vlq_cnt;
	logic [PC_W-1:0]       dispatch;
	opcode_t               op_in;

	mte_ucode u_ucode (
		.pc   (pc_q),
		.word (uword)
	);

	mte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (s_axis_tdata[POS_BPM +: BPM_W]),
		.busy     (div_busy),
		.quotient (tempo_q)
	);

	// input decode
	assign op_in     = opcode_t'(s_axis_tuser);
	assign accept_in = s_axis_tvalid && s_axis_tready;
	assign accum     = accept_in && (op_in == OP_ADD_DELTA);
	assign start_run = accept_in && (s_axis_tuser inside {[OP_NOTE:OP_TRACK_END]});
	assign div_start = accept_in && (op_in == OP_TEMPO);

	// saturating delta accumulation
	assign sum = (VLQ_BITS+1)'(pending_q) + (VLQ_BITS+1)'(s_axis_tdata[POS_DELTA +: DELTA_IN_W]);

	// number of 7-bit groups minus one
	assign pend_ext = VLQ_BITS'(pending_q);
	always_comb begin
		if (|pend_ext[27:21]) begin
			vlq_cnt = 2'd3;
		end else if (|pend_ext[20:14]) begin
			vlq_cnt = 2'd2;
		end else if (|pend_ext[13:7]) begin
			vlq_cnt = 2'd1;
		end else begin
			vlq_cnt = 2'd0;
		end
	end

	// entry point after the delta bytes
	always_comb begin
		case (op_q)
			OP_NOTE:     dispatch = PC_NOTE;
			OP_TEMPO:    dispatch = PC_TEMPO;
			OP_TIME_SIG: dispatch = PC_TSIG;
			default:     dispatch = PC_END;
		endcase
	end

	// byte source selection
	always_comb begin
		case (uword.src)
			SRC_CONST:  out_byte = uword.const_byte;
			SRC_VLQ: begin
				case (vlq_idx_q)
					2'd3:    out_byte = {1'b1, vlq_q[27:21]};
					2'd2:    out_byte = {1'b1, vlq_q[20:14]};
					2'd1:    out_byte = {1'b1, vlq_q[13:7]};
					default: out_byte = {1'b0, vlq_q[6:0]};
				endcase
			end
			SRC_STATUS: out_byte = status_q;
			SRC_A:      out_byte = a_q;
			SRC_B:      out_byte = b_q;
			SRC_C:      out_byte = c_q;
			SRC_D:      out_byte = d_q;
			SRC_Q_HI:   out_byte = tempo_q[23:16];
			SRC_Q_MID:  out_byte = tempo_q[15:8];
			SRC_Q_LO:   out_byte = tempo_q[7:0];
			default:    out_byte = 8'h00;
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= PC_VLQ;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	// next step and byte emission
	always_comb begin
		state_d       = state_q;
		pc_d          = pc_q;
		emit          = 1'b0;
		vlq_dec       = 1'b0;
		status_emit   = 1'b0;
		s_axis_tready = (state_q == ST_IDLE);
		out_free      = !m_valid_q || m_axis_tready;
		// running status: a repeated status byte is skipped
		want_emit     = (uword.src != SRC_NONE) &&
			!((uword.src == SRC_STATUS) && (status_q == last_status_q));
		case (state_q)
			ST_IDLE: begin
				if (start_run) begin
					state_d = ST_RUN;
					pc_d    = PC_VLQ;
				end
			end
			ST_RUN: begin
				if (!want_emit || out_free) begin
					emit        = want_emit;
					status_emit = want_emit && (uword.src == SRC_STATUS);
					case (uword.seq)
						SEQ_NEXT: pc_d = pc_q + 1'b1;
						SEQ_VLQ: begin
							if (vlq_idx_q != '0) begin
								vlq_dec = 1'b1;
							end else begin
								pc_d = dispatch;
							end
						end
						SEQ_DIV_WAIT: begin
							if (!div_busy) begin
								pc_d = pc_q + 1'b1;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// track state: pending delta, running status, group index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			last_status_q <= STATUS_RESET;
			vlq_idx_q     <= '0;
		end else begin
			if (accum) begin
				pending_q <= (sum > DELTA_MAX) ? DELTA_BITS'(DELTA_MAX) : DELTA_BITS'(sum);
			end else if (start_run) begin
				pending_q <= '0;
			end
			if (start_run) begin
				vlq_idx_q <= vlq_cnt;
			end else if (vlq_dec) begin
				vlq_idx_q <= vlq_idx_q - 1'b1;
			end
			if (status_emit) begin
				last_status_q <= status_q;
			end
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_q     <= op_in;
			status_q <= s_axis_tdata[POS_STATUS +: BYTE_W];
			a_q      <= s_axis_tdata[POS_A +: BYTE_W];
			b_q      <= s_axis_tdata[POS_B +: BYTE_W];
			c_q      <= s_axis_tdata[POS_C +: BYTE_W];
			d_q      <= s_axis_tdata[POS_D +: BYTE_W];
		end
		if (start_run) begin
			vlq_q <= pend_ext;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= out_byte;
			m_last_q <= uword.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

FILE: design/mte_checker.sv
`timescale 1ns / 1ps
module mte_checker
	import mte_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [OPCODE_W-1:0]  s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tlast
);

	// a stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output byte changed while stalled");

	// an item that produces bytes makes the block busy
	a_busy_after_event: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
			(s_axis_tuser == OP_NOTE || s_axis_tuser == OP_TEMPO ||
			 s_axis_tuser == OP_TIME_SIG || s_axis_tuser == OP_TRACK_END)
		|=> !s_axis_tready)
		else $error("block ready right after an event item");

	// add delta and unused opcodes leave the block ready
	a_ready_after_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
			!(s_axis_tuser == OP_NOTE || s_axis_tuser == OP_TEMPO ||
			  s_axis_tuser == OP_TIME_SIG || s_axis_tuser == OP_TRACK_END)
		|=> s_axis_tready)
		else $error("block busy after an item with no bytes");

endmodule

bind midi_track_event_encoder mte_checker u_mte_checker (.*);

FILE: test/midi_track_event_encoder_test.sv
`timescale 1ns / 1ps
module midi_track_event_encoder_test;
	import mte_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 5;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 40;
	localparam int RANDOM_ITEMS    = 110;
	localparam int MAX_REPORTS     = 30;
	localparam int TEMPO_USEC_PER_MIN = 60000000;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;
	localparam logic [DELTA_IN_W-1:0] TICKS_MAX = {DELTA_IN_W{1'b1}};
	localparam logic [7:0] VLQ_MORE = 8'h80;

	typedef struct packed {
		logic [DELTA_IN_W-1:0] ticks;
		logic [BYTE_W-1:0]     status;
		logic [BYTE_W-1:0]     a;
		logic [BYTE_W-1:0]     b;
		logic [BYTE_W-1:0]     c;
		logic [BYTE_W-1:0]     d;
		logic [BPM_W-1:0]      bpm;
	} event_fields_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} track_byte_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 s_valid = 1'b0;
	logic [S_TDATA_W-1:0] s_data = '0;
	logic [OPCODE_W-1:0]  s_op = '0;
	logic                 m_ready = 1'b0;
	logic                 s_axis_tready;
	logic                 m_axis_tvalid;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;

	// encoder state as predicted
	logic [DELTA_IN_W-1:0] pending_ticks = '0;
	logic [7:0]            running_status = STATUS_RESET;
	track_byte_t           track_bytes_q[$];

	int mismatches = 0;
	int bytes_checked = 0;
	int op_count[8];
	int burst_left = 0;
	int stall_cycles = 0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int seg_left = 0;
	int stall_mode = 0;
	int stall_period = 2;
	int stall_phase = 0;

	midi_track_event_encoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_op),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// expected stream bytes for one accepted item
	function automatic void encode_event(input logic [OPCODE_W-1:0] op, input event_fields_t f);
		logic [DELTA_IN_W:0]   sum;
		logic [DELTA_IN_W-1:0] v;
		logic [6:0]            groups[4];
		logic [7:0]            bytes[$];
		int                    cnt;
		int                    bpm_eff;
		logic [31:0]           quo;
		track_byte_t           tb;
		if (op == OP_ADD_DELTA) begin
			sum = {1'b0, pending_ticks} + {1'b0, f.ticks};
			pending_ticks = (sum > {1'b0, TICKS_MAX}) ? TICKS_MAX : sum[DELTA_IN_W-1:0];
			return;
		end
		if (op > OP_TRACK_END) begin
			return;
		end
		// delta time as variable-length quantity, high group first
		v = pending_ticks;
		cnt = 0;
		do begin
			groups[cnt] = v[6:0];
			cnt++;
			v = v >> 7;
		end while (v != 0 && cnt < 4);
		for (int i = cnt - 1; i >= 0; i--) begin
			bytes.push_back(i > 0 ? ({1'b0, groups[i]} | VLQ_MORE) : {1'b0, groups[i]});
		end
		pending_ticks = '0;
		case (op)
			OP_NOTE: begin
				// running status
				if (f.status != running_status) begin
					bytes.push_back(f.status);
					running_status = f.status;
				end
				bytes.push_back(f.a);
				bytes.push_back(f.b);
			end
			OP_TEMPO: begin
				bpm_eff = (f.bpm == 0) ? 1 : int'(f.bpm);
				quo = 32'(TEMPO_USEC_PER_MIN / bpm_eff);
				bytes.push_back(META_PREFIX);
				bytes.push_back(META_TEMPO);
				bytes.push_back(META_TEMPO_LEN);
				bytes.push_back(quo[23:16]);
				bytes.push_back(quo[15:8]);
				bytes.push_back(quo[7:0]);
			end
			OP_TIME_SIG: begin
				bytes.push_back(META_PREFIX);
				bytes.push_back(META_TSIG);
				bytes.push_back(META_TSIG_LEN);
				bytes.push_back(f.a);
				bytes.push_back(f.b);
				bytes.push_back(f.c);
				bytes.push_back(f.d);
			end
			default: begin
				bytes.push_back(META_PREFIX);
				bytes.push_back(META_END);
				bytes.push_back(META_END_LEN);
			end
		endcase
		foreach (bytes[i]) begin
			tb.value = bytes[i];
			tb.last = (i == bytes.size() - 1);
			track_bytes_q.push_back(tb);
		end
	endfunction

	function automatic event_fields_t make_fields(input logic [DELTA_IN_W-1:0] ticks,
			input logic [7:0] status, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [BPM_W-1:0] bpm);
		event_fields_t f;
		f.ticks = ticks;
		f.status = status;
		f.a = a;
		f.b = b;
		f.c = c;
		f.d = d;
		f.bpm = bpm;
		return f;
	endfunction

	// sender: bursts of items with random gaps in between
	task automatic send_op(input logic [OPCODE_W-1:0] op, input event_fields_t f);
		logic [S_TDATA_W-1:0] data;
		if (burst_left == 0) begin
			s_valid <= 1'b0;
			s_data <= S_TDATA_W'({$urandom, $urandom, $urandom});
			s_op <= OPCODE_W'($urandom_range(0, 7));
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		// pack the operands, first field in the lowest bits
		data = '0;
		data[POS_DELTA +: DELTA_IN_W] = f.ticks;
		data[POS_STATUS +: BYTE_W] = f.status;
		data[POS_A +: BYTE_W] = f.a;
		data[POS_B +: BYTE_W] = f.b;
		data[POS_C +: BYTE_W] = f.c;
		data[POS_D +: BYTE_W] = f.d;
		data[POS_BPM +: BPM_W] = f.bpm;
		s_valid <= 1'b1;
		s_op <= op;
		s_data <= data;
		do @(posedge clk); while (!s_axis_tready);
		encode_event(op, f);
		op_count[op]++;
		burst_left--;
	endtask

	function automatic logic [DELTA_IN_W-1:0] random_ticks();
		int bits;
		logic [DELTA_IN_W-1:0] v;
		if ($urandom_range(0, 15) == 0) begin
			return TICKS_MAX;
		end
		bits = $urandom_range(0, DELTA_IN_W);
		v = DELTA_IN_W'($urandom);
		if (bits < DELTA_IN_W) begin
			v = v & ((28'd1 << bits) - 28'd1);
		end
		return v;
	endfunction

	function automatic event_fields_t random_fields();
		event_fields_t f;
		logic [7:0] pool[4];
		pool = '{8'h90, 8'h80, 8'hB0, 8'h9F};
		f.ticks = random_ticks();
		// a small pool of status bytes so running status kicks in often
		f.status = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 3)]
			: 8'($urandom_range(0, 255));
		f.a = 8'($urandom_range(0, 255));
		f.b = 8'($urandom_range(0, 255));
		f.c = 8'($urandom_range(0, 255));
		f.d = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: f.bpm = '0;
			1: f.bpm = BPM_W'($urandom_range(1, 300));
			default: f.bpm = BPM_W'($urandom_range(0, 65535));
		endcase
		return f;
	endfunction

	// extremes, running status, saturation and ignored opcodes
	task automatic test_directed_events();
		send_op(OP_TRACK_END, make_fields(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_NOTE, make_fields(0, STATUS_RESET, 8'h00, 8'hFF, 8'h00, 8'h00, 0));
		send_op(OP_NOTE, make_fields(0, 8'h90, 8'hFF, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_NOTE, make_fields(0, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h00, 0));
		send_op(OP_ADD_DELTA, make_fields(28'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_NOTE, make_fields(TICKS_MAX, 8'h80, 8'h3C, 8'h00, 8'hFF, 8'hFF, 16'hFFFF));
		send_op(OP_ADD_DELTA, make_fields(28'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_TEMPO, make_fields(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_ADD_DELTA, make_fields(28'h3FFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_TEMPO, make_fields(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1));
		send_op(OP_ADD_DELTA, make_fields(28'h4000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_TEMPO, make_fields(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF));
		send_op(OP_ADD_DELTA, make_fields(28'h1FFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_TIME_SIG, make_fields(0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 0));
		send_op(OP_ADD_DELTA, make_fields(28'h200000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_TIME_SIG, make_fields(0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 0));
		// two full-scale adds saturate the pending delta
		send_op(OP_ADD_DELTA, make_fields(TICKS_MAX, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_ADD_DELTA, make_fields(TICKS_MAX, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_NOTE, make_fields(0, 8'h00, 8'h40, 8'h40, 8'h00, 8'h00, 0));
		// ignored opcodes must keep the pending delta and running status
		send_op(OP_ADD_DELTA, make_fields(28'd5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_UNUSED_FIRST, make_fields(TICKS_MAX, 8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			16'hFFFF));
		send_op(OP_UNUSED_LAST, make_fields(TICKS_MAX, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		// meta event between notes keeps running status
		send_op(OP_TEMPO, make_fields(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd120));
		send_op(OP_NOTE, make_fields(0, 8'h00, 8'h41, 8'h00, 8'h00, 8'h00, 0));
		send_op(OP_TRACK_END, make_fields(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
	endtask

	// mostly well-formed delta plus event sequences, some noise
	task automatic test_random_tracks();
		int sent;
		int n_adds;
		int pick;
		logic [OPCODE_W-1:0] op;
		event_fields_t f;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0) begin
				n_adds = $urandom_range(0, 3);
				repeat (n_adds) begin
					f = random_fields();
					if ($urandom_range(0, 1) == 0) begin
						f.ticks = DELTA_IN_W'($urandom_range(0, 200));
					end
					send_op(OP_ADD_DELTA, f);
					sent++;
				end
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					op = OP_NOTE;
				end else if (pick < 72) begin
					op = OP_TEMPO;
				end else if (pick < 87) begin
					op = OP_TIME_SIG;
				end else begin
					op = OP_TRACK_END;
				end
				send_op(op, random_fields());
				sent++;
			end else begin
				f.ticks = DELTA_IN_W'($urandom);
				f.status = 8'($urandom);
				f.a = 8'($urandom);
				f.b = 8'($urandom);
				f.c = 8'($urandom);
				f.d = 8'($urandom);
				f.bpm = BPM_W'($urandom);
				op = ($urandom_range(0, 3) == 0)
					? 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST))
					: 3'($urandom_range(OP_ADD_DELTA, OP_TRACK_END));
				send_op(op, f);
				if (op <= OP_TRACK_END) begin
					sent++;
				end
			end
		end
	endtask

	// receiver holds off while items keep coming, so the input stalls
	task automatic test_output_hold();
		hold_asked++;
		repeat (16) begin
			send_op(($urandom_range(0, 1) == 0) ? OP_NOTE : OP_TIME_SIG, random_fields());
		end
	endtask

	// receiver: long hold on request, otherwise changing stall patterns
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_ready <= 1'b0;
		end else if (hold_taken != hold_asked) begin
			hold_taken++;
			hold_left = HOLD_CYCLES - 1;
			m_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 200);
				stall_mode = $urandom_range(0, 2);
				stall_period = $urandom_range(2, 9);
			end
			seg_left--;
			stall_phase++;
			case (stall_mode)
				0: m_ready <= 1'b1;
				1: m_ready <= 1'($urandom_range(0, 1));
				default: m_ready <= (stall_phase % stall_period) != 0;
			endcase
		end
	end

	// compare each output byte with the oldest expected one
	always @(posedge clk) begin : stream_checker
		track_byte_t want;
		if (arst_n && m_axis_tvalid && m_ready) begin
			if (track_bytes_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = track_bytes_q.pop_front();
				bytes_checked++;
				if (m_axis_tdata !== want.value) begin
					report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
						bytes_checked, m_axis_tdata, want.value));
				end
				if (m_axis_tlast !== want.last) begin
					report_mismatch($sformatf("byte %0d: last_byte %0b, want %0b",
						bytes_checked, m_axis_tlast, want.last));
				end
			end
		end
	end

	// no progress while work is outstanding ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
				stall_cycles <= 0;
			end else if (s_valid || track_bytes_q.size() != 0) begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("no item moved for %0d cycles, %0d bytes outstanding",
					stall_cycles, track_bytes_q.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		foreach (op_count[i]) op_count[i] = 0;
		// falling edge on reset once all processes wait on their events
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_random_tracks();
		test_output_hold();
		test_random_tracks();
		s_valid <= 1'b0;
		while (track_bytes_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (track_bytes_q.size() != 0) begin
			report_mismatch($sformatf("%0d bytes never arrived", track_bytes_q.size()));
		end
		$display("run covered %0d delta adds, %0d notes, %0d tempos, %0d time signatures,",
			op_count[OP_ADD_DELTA], op_count[OP_NOTE], op_count[OP_TEMPO],
			op_count[OP_TIME_SIG]);
		$display("%0d track ends, %0d ignored opcodes; %0d bytes compared, %0d mismatches",
			op_count[OP_TRACK_END],
			op_count[OP_UNUSED_FIRST] + op_count[OP_UNUSED_FIRST + 3'd1]
				+ op_count[OP_UNUSED_LAST],
			bytes_checked, mismatches);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/mte_pkg.sv
design/mte_ucode.sv
design/mte_div.sv
design/midi_track_event_encoder.sv
design/mte_checker.sv
test/midi_track_event_encoder_test.sv
